// ===== rtl/radix_digit_converter_assert.svh =====
// Assertion macros for the radix digit converter.
// Define ASSERT_OFF to compile the checks away.
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define RDC_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("radix digit converter: same-cycle check failed");
`define RDC_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("radix digit converter: next-cycle check failed");
`else
`define RDC_ASSERT_IMP(label, clk, rst_n, pre, post)
`define RDC_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/rdc_pkg.sv =====
`default_nettype none
package rdc_pkg;

	localparam int MAX_DIGITS     = 63;
	localparam int IDX_W          = $clog2(MAX_DIGITS);
	localparam int VALUE_W        = 63;
	localparam int DIVD_W         = 64;
	localparam int BITS_PER_CYCLE = 8;
	localparam int DIV_CYCLES     = DIVD_W / BITS_PER_CYCLE;
	localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);
	localparam int RADIX_W        = 5;
	localparam int CHAR_W         = 8;
	localparam int PROD_W         = VALUE_W + RADIX_W;

	localparam logic OP_FORMAT = 1'b0;
	localparam logic OP_PARSE  = 1'b1;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_BADCHAR = 2'd1;
	localparam logic [1:0] STAT_OVF     = 2'd2;

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_RD,
		S_EMIT,
		S_PRES
	} state_t;

	typedef struct packed {
		logic fmt_load;
		logic div_step;
		logic mem_rd;
		logic emit;
		logic par_step;
		logic par_emit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic div_done;
		logic emit_last;
	} sts_t;

	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN)
			res = RADIX_MIN;
		else if (r > RADIX_MAX)
			res = RADIX_MAX;
		return res;
	endfunction

	// 16 means outside the alphabet
	function automatic logic [4:0] char_to_digit(input logic [CHAR_W-1:0] c);
		logic [4:0] d;
		d = 5'd16;
		if (c >= "0" && c <= "9")
			d = 5'(c - "0");
		else if (c >= "A" && c <= "F")
			d = 5'(c - "A" + 8'd10);
		return d;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [3:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10)
			c = CHAR_W'("0") + CHAR_W'(d);
		else
			c = CHAR_W'("A") + CHAR_W'(d - 4'd10);
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/rdc_if.sv =====
`default_nettype none
interface rdc_in_if import rdc_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [VALUE_W-1:0]   value;
	logic [RADIX_W-1:0]   radix;
	logic [CHAR_W-1:0]    digit_char;
	logic                 last_char;

	modport source (output valid, op, value, radix, digit_char, last_char, input ready);
	modport sink   (input valid, op, value, radix, digit_char, last_char, output ready);
endinterface

interface rdc_out_if import rdc_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CHAR_W-1:0]    out_char;
	logic [VALUE_W-1:0]   out_value;
	logic                 last;
	logic [1:0]           status;

	modport source (output valid, out_char, out_value, last, status, input ready);
	modport sink   (input valid, out_char, out_value, last, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/radix_digit_converter.sv =====
`default_nettype none
`include "radix_digit_converter_assert.svh"
// Radix digit converter, radix 2 to 16 over the digits 0-9A-F. A format beat (op 0)
// takes one value and gives its digits most significant first, one beat per digit,
// with last on the final digit; zero gives a single '0'. Each digit is computed by
// the 64-bit restoring divider (8 quotient bits per cycle) and kept in the digit
// store; readout takes each digit through S_RD and S_EMIT, most significant first,
// and waits in S_EMIT while the output register is full. A parse beat (op 1)
// carries one character; the beat marked last_char is followed by S_PRES, which
// loads the parsed value into the output register once it is free. Bad characters
// count as 0 and report status 1, accumulator overflow reports status 2. The
// output register lets a new item in while the previous result is still waiting.
module radix_digit_converter import rdc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rdc_in_if.sink     din,
	rdc_out_if.source  dout
);

	cmd_t   cmd;
	sts_t   sts;
	state_t state;

	rdc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (din.valid),
		.in_op        (din.op),
		.in_last_char (din.last_char),
		.in_ready     (din.ready),
		.sts          (sts),
		.cmd          (cmd),
		.state        (state)
	);

	rdc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.value      (din.value),
		.radix      (din.radix),
		.digit_char (din.digit_char),
		.out_ready  (dout.ready),
		.out_valid  (dout.valid),
		.out_char   (dout.out_char),
		.out_value  (dout.out_value),
		.out_last   (dout.last),
		.out_status (dout.status)
	);

	`RDC_ASSERT_IMP(a_busy_no_accept, clk, arst_n, state != S_IDLE, !din.ready)
	`RDC_ASSERT_NXT(a_fmt_starts_div, clk, arst_n, din.valid && din.ready && din.op == OP_FORMAT, state == S_DIV)
	`RDC_ASSERT_IMP(a_fmt_no_value, clk, arst_n, dout.valid && dout.out_char != '0, dout.out_value == '0)
	`RDC_ASSERT_IMP(a_fmt_no_badchar, clk, arst_n, dout.valid && dout.out_char != '0, dout.status != STAT_BADCHAR)

endmodule
`default_nettype wire

// ===== rtl/rdc_datapath.sv =====
`default_nettype none
module rdc_datapath import rdc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic [VALUE_W-1:0]   value,
	input  logic [RADIX_W-1:0]   radix,
	input  logic [CHAR_W-1:0]    digit_char,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [CHAR_W-1:0]    out_char,
	output logic [VALUE_W-1:0]   out_value,
	output logic                 out_last,
	output logic [1:0]           out_status
);

	// format state
	logic [DIVD_W-1:0]    divd_q;
	logic [3:0]           rem_q;
	logic [RADIX_W-1:0]   radix_q;
	logic [DIV_CNT_W-1:0] bitcnt_q;
	logic [IDX_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic [1:0]           st_q;
	logic [3:0]           rd_q;
	logic [3:0]           digit_mem [MAX_DIGITS];

	// parse state
	logic [VALUE_W-1:0]   acc_q;
	logic [1:0]           perr_q;

	// output register
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic [VALUE_W-1:0]   out_value_q;
	logic                 out_last_q;
	logic [1:0]           out_status_q;

	logic [DIVD_W-1:0]    dq_next;
	logic [3:0]           rem_next;
	logic                 div_last;
	logic                 quot_zero;
	logic                 store_full;

	logic [RADIX_W-1:0]   prs_radix;
	logic [4:0]           prs_dig;
	logic                 prs_bad;
	logic [3:0]           prs_d;
	logic [PROD_W-1:0]    prs_sum;
	logic                 prs_ovf;
	logic [1:0]           prs_err;

	// restoring division, several quotient bits per cycle
	always_comb begin
		logic [4:0] t;
		logic [3:0] r;
		logic [DIVD_W-1:0] dq;
		r  = rem_q;
		dq = divd_q;
		for (int i = 0; i < BITS_PER_CYCLE; i++) begin
			t  = {r, dq[DIVD_W-1]};
			dq = {dq[DIVD_W-2:0], 1'b0};
			if (t >= radix_q) begin
				r     = 4'(t - radix_q);
				dq[0] = 1'b1;
			end else begin
				r = t[3:0];
			end
		end
		dq_next  = dq;
		rem_next = r;
	end

	assign div_last   = (bitcnt_q == DIV_CNT_W'(DIV_CYCLES - 1));
	assign quot_zero  = (dq_next == '0);
	assign store_full = (cnt_q == IDX_W'(MAX_DIGITS - 1));

	always_comb begin
		prs_radix = clamp_radix(radix);
		prs_dig   = char_to_digit(digit_char);
		prs_bad   = (prs_dig >= prs_radix);
		prs_d     = prs_bad ? 4'd0 : prs_dig[3:0];
		prs_sum   = PROD_W'(acc_q) * PROD_W'(prs_radix) + PROD_W'(prs_d);
		prs_ovf   = |prs_sum[PROD_W-1:VALUE_W];
		if (prs_ovf)
			prs_err = STAT_OVF;
		else if (prs_bad && perr_q == STAT_OK)
			prs_err = STAT_BADCHAR;
		else
			prs_err = perr_q;
	end

	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.div_done  = div_last && (quot_zero || store_full);
	assign sts.emit_last = (rd_idx_q == '0);

	// format control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitcnt_q <= '0;
			cnt_q    <= '0;
			rd_idx_q <= '0;
			st_q     <= STAT_OK;
		end else begin
			if (cmd.fmt_load) begin
				bitcnt_q <= '0;
				cnt_q    <= '0;
				st_q     <= STAT_OK;
			end else if (cmd.div_step) begin
				bitcnt_q <= bitcnt_q + 1'b1;
				if (div_last) begin
					cnt_q    <= cnt_q + 1'b1;
					rd_idx_q <= cnt_q;
					if (store_full && !quot_zero)
						st_q <= STAT_OVF;
				end
			end else if (cmd.emit) begin
				rd_idx_q <= rd_idx_q - 1'b1;
			end
		end
	end

	// divider payload
	always_ff @(posedge clk) begin
		if (cmd.fmt_load) begin
			divd_q  <= {1'b0, value};
			rem_q   <= '0;
			radix_q <= clamp_radix(radix);
		end else if (cmd.div_step) begin
			divd_q <= dq_next;
			rem_q  <= div_last ? 4'd0 : rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_step && div_last)
			digit_mem[cnt_q] <= rem_next;
		if (cmd.mem_rd)
			rd_q <= digit_mem[rd_idx_q];
	end

	// parse accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			perr_q <= STAT_OK;
		end else if (cmd.par_step) begin
			acc_q  <= prs_sum[VALUE_W-1:0];
			perr_q <= prs_err;
		end else if (cmd.par_emit) begin
			acc_q  <= '0;
			perr_q <= STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit || cmd.par_emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_char_q   <= digit_to_char(rd_q);
			out_value_q  <= '0;
			out_last_q   <= (rd_idx_q == '0);
			out_status_q <= st_q;
		end else if (cmd.par_emit) begin
			out_char_q   <= '0;
			out_value_q  <= acc_q;
			out_last_q   <= 1'b1;
			out_status_q <= perr_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign out_value  = out_value_q;
	assign out_last   = out_last_q;
	assign out_status = out_status_q;

endmodule
`default_nettype wire

// ===== rtl/rdc_ctrl.sv =====
`default_nettype none
module rdc_ctrl import rdc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  logic   in_op,
	input  logic   in_last_char,
	output logic   in_ready,
	input  sts_t   sts,
	output cmd_t   cmd,
	output state_t state
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_FORMAT) begin
						cmd.fmt_load = 1'b1;
						state_d      = S_DIV;
					end else begin
						cmd.par_step = 1'b1;
						if (in_last_char)
							state_d = S_PRES;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done)
					state_d = S_RD;
			end
			S_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				// hold until the output register frees up
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.emit_last ? S_IDLE : S_RD;
				end
			end
			S_PRES: begin
				if (sts.out_free) begin
					cmd.par_emit = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign state = state_q;

endmodule
`default_nettype wire
